@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk, off while rst is high.
`define ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check prop on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

@@ design/rbi_pkg.sv @@
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared types and constants of the 2D ray/box intersection block.
// ----------------------------------------------------------------------------
package rbi_pkg;

   localparam int DIST_BITS    = 32;
   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_DIR_X    = 2'd2,
      CSR_DIR_Y    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic empty;
      logic interior;
      logic edge_x;
      logic edge_y;
   } cls_type;

   localparam int CLS_BITS = $bits(cls_type);

endpackage

@@ design/ray_box_intersect_2d.sv @@
// ----------------------------------------------------------------------------
// ray_box_intersect_2d
// Tests one configured 2D ray against a stream of axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Write the ray origin and direction (signed fixed point) through the
//   csr_ port while no item is in flight. Push one box per item on the req_
//   side; every box gives one result (hit flag, unsigned distance in
//   direction units, saturated) on the rsp_ side, in order.
// Throughput: one item per cycle while the result queue is not full, set by
//   the bit-per-stage divider pipeline of the back end.
// Reset: empties both queues and the pipeline, origin to 0, direction
//   to (1.0, 0).
// Stall: with pop held low the back pipeline freezes once the two-entry
//   result queue fills, then the four-entry middle queue fills and full
//   rises; nothing is dropped.
// ----------------------------------------------------------------------------
module ray_box_intersect_2d
   import rbi_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [COORD_BITS-1:0]        csr_wdata,
   input  logic                         push,
   output logic                         full,
   input  logic signed [COORD_BITS-1:0] req_box_min_x,
   input  logic signed [COORD_BITS-1:0] req_box_min_y,
   input  logic signed [COORD_BITS-1:0] req_box_max_x,
   input  logic signed [COORD_BITS-1:0] req_box_max_y,
   output logic                         empty,
   input  logic                         pop,
   output logic                         rsp_hit,
   output logic [DIST_BITS-1:0]         rsp_distance
);

   localparam int W1     = COORD_BITS + 1;
   localparam int MID_W  = CLS_BITS + 6 * W1;
   localparam int OUT_W  = 1 + DIST_BITS;

   logic signed [COORD_BITS-1:0] origin_x_ff, origin_y_ff, dir_x_ff, dir_y_ff;

   cls_type             f_cls, b_cls;
   logic [W1-1:0]       f_nx, f_ny, b_nx, b_ny;
   logic signed [W1-1:0] f_sxl, f_sxh, f_syl, f_syh, b_sxl, b_sxh, b_syl, b_syh;
   logic [MID_W-1:0]    mid_in, mid_out;
   logic                mid_empty, mid_pop;
   logic                out_full, out_push, out_hit;
   logic [DIST_BITS-1:0] out_distance;
   logic [OUT_W-1:0]    rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         dir_x_ff    <= COORD_BITS'(1) << FRAC_BITS;
         dir_y_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            CSR_DIR_X:    dir_x_ff    <= csr_wdata;
            CSR_DIR_Y:    dir_y_ff    <= csr_wdata;
            default:      ;
         endcase
      end
   end

   rbi_front #(.COORD_BITS(COORD_BITS)) u_front (
      .origin_x  (origin_x_ff),
      .origin_y  (origin_y_ff),
      .dir_x     (dir_x_ff),
      .dir_y     (dir_y_ff),
      .box_min_x (req_box_min_x),
      .box_min_y (req_box_min_y),
      .box_max_x (req_box_max_x),
      .box_max_y (req_box_max_y),
      .cls       (f_cls),
      .num_x     (f_nx),
      .num_y     (f_ny),
      .span_x_lo (f_sxl),
      .span_x_hi (f_sxh),
      .span_y_lo (f_syl),
      .span_y_hi (f_syh)
   );

   assign mid_in = {f_cls, f_nx, f_ny, f_sxl, f_sxh, f_syl, f_syh};
   assign {b_cls, b_nx, b_ny, b_sxl, b_sxh, b_syl, b_syh} = mid_out;

   rbi_fifo #(.WIDTH(MID_W), .DEPTH(4)) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .push_data (mid_in),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .pop_data  (mid_out)
   );

   rbi_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .dir_x        (dir_x_ff),
      .dir_y        (dir_y_ff),
      .mid_empty    (mid_empty),
      .mid_pop      (mid_pop),
      .cls          (b_cls),
      .num_x        (b_nx),
      .num_y        (b_ny),
      .span_x_lo    (b_sxl),
      .span_x_hi    (b_sxh),
      .span_y_lo    (b_syl),
      .span_y_hi    (b_syh),
      .out_full     (out_full),
      .out_push     (out_push),
      .out_hit      (out_hit),
      .out_distance (out_distance)
   );

   rbi_fifo #(.WIDTH(OUT_W), .DEPTH(2)) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .full      (out_full),
      .push_data ({out_hit, out_distance}),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (rsp_data)
   );

   assign {rsp_hit, rsp_distance} = rsp_data;

endmodule

@@ design/rbi_fifo.sv @@
// ----------------------------------------------------------------------------
// rbi_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rbi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
`include "assert_macros.svh"

   localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CB = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PB-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CB-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CB'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == PB'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == PB'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CB'(do_push) - CB'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   `ASSERT_RST(a_not_full_and_empty, clock, reset, !(full && empty))
   `ASSERT_RST(a_push_fills, clock, reset, (push && !full) |=> !empty)
   `ASSERT_RST(a_last_pop_drains, clock, reset,
      (pop && !empty && !push && cnt_ff == CB'(1)) |=> empty)

endmodule

@@ design/rbi_front.sv @@
// ----------------------------------------------------------------------------
// rbi_front
// Classify one box against the ray and form edge distances and spans.
// ----------------------------------------------------------------------------
module rbi_front
   import rbi_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic signed [COORD_BITS-1:0] origin_x,
   input  logic signed [COORD_BITS-1:0] origin_y,
   input  logic signed [COORD_BITS-1:0] dir_x,
   input  logic signed [COORD_BITS-1:0] dir_y,
   input  logic signed [COORD_BITS-1:0] box_min_x,
   input  logic signed [COORD_BITS-1:0] box_min_y,
   input  logic signed [COORD_BITS-1:0] box_max_x,
   input  logic signed [COORD_BITS-1:0] box_max_y,
   output cls_type                      cls,
   output logic        [COORD_BITS:0]   num_x,
   output logic        [COORD_BITS:0]   num_y,
   output logic signed [COORD_BITS:0]   span_x_lo,
   output logic signed [COORD_BITS:0]   span_x_hi,
   output logic signed [COORD_BITS:0]   span_y_lo,
   output logic signed [COORD_BITS:0]   span_y_hi
);

   localparam int W = COORD_BITS + 1;

   logic signed [W-1:0] ox, oy, diff_x, diff_y;
   logic                dx_pos, dx_neg, dy_pos, dy_neg;

   always_comb begin
      ox     = {origin_x[COORD_BITS-1], origin_x};
      oy     = {origin_y[COORD_BITS-1], origin_y};
      dx_pos = !dir_x[COORD_BITS-1] && (dir_x != '0);
      dx_neg = dir_x[COORD_BITS-1];
      dy_pos = !dir_y[COORD_BITS-1] && (dir_y != '0);
      dy_neg = dir_y[COORD_BITS-1];

      cls.empty    = (box_min_x > box_max_x) || (box_min_y > box_max_y);
      cls.interior = (origin_x > box_min_x) && (origin_y > box_min_y)
                  && (origin_x < box_max_x) && (origin_y < box_max_y);
      cls.edge_x = (dx_pos && (origin_x <= box_min_x))
                || (dx_neg && (origin_x >= box_max_x));
      cls.edge_y = (dy_pos && (origin_y <= box_min_y))
                || (dy_neg && (origin_y >= box_max_y));

      diff_x = (dx_pos ? {box_min_x[COORD_BITS-1], box_min_x}
                       : {box_max_x[COORD_BITS-1], box_max_x}) - ox;
      diff_y = (dy_pos ? {box_min_y[COORD_BITS-1], box_min_y}
                       : {box_max_y[COORD_BITS-1], box_max_y}) - oy;
      num_x  = diff_x[W-1] ? W'(0) - diff_x : diff_x;
      num_y  = diff_y[W-1] ? W'(0) - diff_y : diff_y;

      span_x_lo = {box_min_y[COORD_BITS-1], box_min_y} - oy;
      span_x_hi = {box_max_y[COORD_BITS-1], box_max_y} - oy;
      span_y_lo = {box_min_x[COORD_BITS-1], box_min_x} - ox;
      span_y_hi = {box_max_x[COORD_BITS-1], box_max_x} - ox;
   end

endmodule

@@ design/rbi_back.sv @@
// ----------------------------------------------------------------------------
// rbi_back
// Span test by cross products and pipelined edge division, one bit a stage.
// ----------------------------------------------------------------------------
module rbi_back
   import rbi_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-1:0] dir_x,
   input  logic signed [COORD_BITS-1:0] dir_y,
   input  logic                         mid_empty,
   output logic                         mid_pop,
   input  cls_type                      cls,
   input  logic        [COORD_BITS:0]   num_x,
   input  logic        [COORD_BITS:0]   num_y,
   input  logic signed [COORD_BITS:0]   span_x_lo,
   input  logic signed [COORD_BITS:0]   span_x_hi,
   input  logic signed [COORD_BITS:0]   span_y_lo,
   input  logic signed [COORD_BITS:0]   span_y_hi,
   input  logic                         out_full,
   output logic                         out_push,
   output logic                         out_hit,
   output logic        [DIST_BITS-1:0]  out_distance
);

   localparam int W1 = COORD_BITS + 1;
   localparam int W2 = COORD_BITS + 2;
   localparam int PW = 2 * W2;
   localparam int RW = COORD_BITS + DIST_BITS + FRAC_BITS + 2;
   localparam int L  = DIST_BITS;

   logic              en;
   logic [W1-1:0]     dmx, dmy;
   logic [RW-1:0]     rem_x_init, rem_y_init;

   logic              v_ff     [0:L];
   cls_type           cls_ff   [0:L];
   logic              sat_x_ff [0:L];
   logic              sat_y_ff [0:L];
   logic [DIST_BITS-1:0] q_x_ff [0:L];
   logic [DIST_BITS-1:0] q_y_ff [0:L];
   logic [RW-1:0]     rem_x_ff [0:L-1];
   logic [RW-1:0]     rem_y_ff [0:L-1];
   logic              ok_x_ff  [1:L];
   logic              ok_y_ff  [1:L];

   logic signed [PW-1:0] pxl_ff, pxm_ff, pxh_ff, pyl_ff, pym_ff, pyh_ff;
   logic signed [PW-1:0] pxl_in, pxm_in, pxh_in, pyl_in, pym_in, pyh_in;

   logic [DIST_BITS-1:0] tx, ty;

   assign en      = !out_full;
   assign mid_pop = en && !mid_empty;

   always_comb begin
      dmx = dir_x[COORD_BITS-1] ? W1'(0) - {dir_x[COORD_BITS-1], dir_x} : {1'b0, dir_x};
      dmy = dir_y[COORD_BITS-1] ? W1'(0) - {dir_y[COORD_BITS-1], dir_y} : {1'b0, dir_y};
      rem_x_init = RW'({num_x, {FRAC_BITS{1'b0}}});
      rem_y_init = RW'({num_y, {FRAC_BITS{1'b0}}});
      pxl_in = PW'($signed({span_x_lo[COORD_BITS], span_x_lo})) * PW'($signed({1'b0, dmx}));
      pxh_in = PW'($signed({span_x_hi[COORD_BITS], span_x_hi})) * PW'($signed({1'b0, dmx}));
      pxm_in = PW'($signed({{2{dir_y[COORD_BITS-1]}}, dir_y})) * PW'($signed({1'b0, num_x}));
      pyl_in = PW'($signed({span_y_lo[COORD_BITS], span_y_lo})) * PW'($signed({1'b0, dmy}));
      pyh_in = PW'($signed({span_y_hi[COORD_BITS], span_y_hi})) * PW'($signed({1'b0, dmy}));
      pym_in = PW'($signed({{2{dir_x[COORD_BITS-1]}}, dir_x})) * PW'($signed({1'b0, num_y}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= !mid_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cls_ff[0]   <= cls;
         sat_x_ff[0] <= RW'(num_x) >= (RW'(dmx) << (DIST_BITS - FRAC_BITS));
         sat_y_ff[0] <= RW'(num_y) >= (RW'(dmy) << (DIST_BITS - FRAC_BITS));
         q_x_ff[0]   <= '0;
         q_y_ff[0]   <= '0;
         rem_x_ff[0] <= rem_x_init;
         rem_y_ff[0] <= rem_y_init;
         pxl_ff      <= pxl_in;
         pxm_ff      <= pxm_in;
         pxh_ff      <= pxh_in;
         pyl_ff      <= pyl_in;
         pym_ff      <= pym_in;
         pyh_ff      <= pyh_in;
      end
   end

   for (genvar j = 1; j <= L; j++) begin : g_stage
      localparam int K = L - j;
      logic [RW-1:0] dsh_x, dsh_y;
      logic          ge_x, ge_y;

      assign dsh_x = RW'(dmx) << K;
      assign dsh_y = RW'(dmy) << K;
      assign ge_x  = rem_x_ff[j-1] >= dsh_x;
      assign ge_y  = rem_y_ff[j-1] >= dsh_y;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cls_ff[j]   <= cls_ff[j-1];
            sat_x_ff[j] <= sat_x_ff[j-1];
            sat_y_ff[j] <= sat_y_ff[j-1];
            q_x_ff[j]   <= q_x_ff[j-1] | (DIST_BITS'(ge_x) << K);
            q_y_ff[j]   <= q_y_ff[j-1] | (DIST_BITS'(ge_y) << K);
         end
      end

      if (j < L) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_x_ff[j] <= ge_x ? rem_x_ff[j-1] - dsh_x : rem_x_ff[j-1];
               rem_y_ff[j] <= ge_y ? rem_y_ff[j-1] - dsh_y : rem_y_ff[j-1];
            end
         end
      end

      if (j == 1) begin : g_span
         always_ff @(posedge clock) begin
            if (en) begin
               ok_x_ff[j] <= cls_ff[0].edge_x && !(pxl_ff > pxm_ff) && !(pxm_ff > pxh_ff);
               ok_y_ff[j] <= cls_ff[0].edge_y && !(pyl_ff > pym_ff) && !(pym_ff > pyh_ff);
            end
         end
      end else begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               ok_x_ff[j] <= ok_x_ff[j-1];
               ok_y_ff[j] <= ok_y_ff[j-1];
            end
         end
      end
   end

   always_comb begin
      tx = sat_x_ff[L] ? '1 : q_x_ff[L];
      ty = sat_y_ff[L] ? '1 : q_y_ff[L];
      out_push = v_ff[L] && en;
      if (cls_ff[L].empty) begin
         out_hit      = 1'b0;
         out_distance = '0;
      end else if (cls_ff[L].interior) begin
         out_hit      = 1'b1;
         out_distance = '0;
      end else begin
         out_hit = ok_x_ff[L] || ok_y_ff[L];
         if (ok_x_ff[L] && ok_y_ff[L]) begin
            out_distance = (tx < ty) ? tx : ty;
         end else if (ok_x_ff[L]) begin
            out_distance = tx;
         end else if (ok_y_ff[L]) begin
            out_distance = ty;
         end else begin
            out_distance = '0;
         end
      end
   end

endmodule
